@@ rtl/jls_pkg.sv @@
// Shared types and constants of the Jacobi four-point stencil sweep unit.
`timescale 1ns / 1ps
`default_nettype none

package jls_pkg;

  localparam int VALUE_BITS = 32;
  localparam int IN_TDATA_BITS = 32;
  localparam int OUT_TDATA_BITS = 64;

  localparam int CFG_COLS_BITS = 13;
  localparam int CFG_ROWS_BITS = 16;
  localparam int CFG_IDX_BITS = 1;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [CFG_IDX_BITS-1:0] REG_GRID_COLS = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_GRID_ROWS = 1'b1;

  localparam int FIFO_DEPTH = 16;
  localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);
  localparam int PEND_BITS = 3;
  localparam int RESERVE_BITS = 5;

  typedef logic signed [VALUE_BITS-1:0] value_t;

  typedef struct packed {
    logic interior;
    logic emit_relaxed;
    logic emit_border;
    logic sweep_end;
    logic sweep_start;
  } flags_t;

  typedef struct packed {
    value_t left;
    value_t right;
    value_t up;
    value_t down;
    value_t centre;
    flags_t flags;
  } operands_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] max_change;
    logic                  sweep_last;
    value_t                new_value;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

`default_nettype wire

@@ rtl/jls_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module jls_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/jls_window.sv @@
// Line buffers, grid position counters and operand gathering for the stencil.
`timescale 1ns / 1ps
`default_nettype none

module jls_window #(
  parameter int MAX_COLS = 4096
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [jls_pkg::CFG_IDX_BITS-1:0] cfg_idx,
  input  logic [jls_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
  input  logic                             accept,
  input  jls_pkg::value_t                  cell_value,
  output logic                             run,
  output logic                             op_valid,
  output jls_pkg::operands_t               op
);

  import jls_pkg::*;

  localparam int CW = $clog2(MAX_COLS + 1);
  localparam int AW = $clog2(MAX_COLS);
  localparam int CMPW = (CW > CFG_COLS_BITS) ? CW : CFG_COLS_BITS;
  localparam int ENTRY_BITS = 2 * VALUE_BITS;

  typedef enum logic [1:0] {ST_CLEAR, ST_FETCH_CUR, ST_FETCH_NEXT, ST_RUN} state_t;

  state_t                     state_r, state_nxt;
  logic [AW-1:0]              clr_addr_r, clr_addr_nxt;
  logic [CFG_COLS_BITS-1:0]   grid_cols_r, grid_cols_nxt;
  logic [CFG_ROWS_BITS-1:0]   grid_rows_r, grid_rows_nxt;
  logic [CW-1:0]              col_r, col_nxt;
  logic [CFG_ROWS_BITS-1:0]   row_r, row_nxt;
  logic [ENTRY_BITS-1:0]      a_r, a_nxt;
  value_t                     prev_centre_r, prev_centre_nxt;
  logic                       op_valid_r;
  operands_t                  op_r, op_nxt;

  logic                       ram_we, ram_re;
  logic [AW-1:0]              ram_waddr, ram_raddr;
  logic [ENTRY_BITS-1:0]      ram_wdata, ram_rdata;

  logic [CMPW-1:0]            cols_ext;
  logic [CW-1:0]              cols_eff;
  logic [CFG_ROWS_BITS-1:0]   rows_eff;
  logic                       col_wrap, row_wrap, has_right;
  logic [CFG_ROWS_BITS:0]     row_inc;
  logic [CW-1:0]              pos_c, pos_c_p1, n1, n2;
  logic [CFG_ROWS_BITS-1:0]   pos_row;
  value_t                     centre;

  function automatic logic [CW-1:0] seq_next(input logic [CW-1:0] c,
                                             input logic [CW-1:0] cols);
    logic [CW-1:0] c1;
    c1 = c + CW'(1);
    return (c1 < cols) ? c1 : '0;
  endfunction

  jls_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (MAX_COLS)
  ) u_lines (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Effective grid size and the position of the next cell, wrapped lazily as
  // the counters stand, so that a size change between sweeps is honored.
  always_comb begin
    cols_ext = CMPW'(grid_cols_r);
    if (cols_ext < CMPW'(3)) begin
      cols_eff = CW'(3);
    end else if (cols_ext > CMPW'(MAX_COLS)) begin
      cols_eff = CW'(MAX_COLS);
    end else begin
      cols_eff = cols_ext[CW-1:0];
    end
    rows_eff = (grid_rows_r < CFG_ROWS_BITS'(3)) ? CFG_ROWS_BITS'(3) : grid_rows_r;

    col_wrap = (col_r >= cols_eff);
    row_inc  = {1'b0, row_r} + (CFG_ROWS_BITS + 1)'(col_wrap);
    row_wrap = (row_inc >= {1'b0, rows_eff});
    pos_c    = (col_wrap || row_wrap) ? '0 : col_r;
    pos_row  = row_wrap ? '0 : row_inc[CFG_ROWS_BITS-1:0];
    pos_c_p1 = pos_c + CW'(1);
    has_right = (pos_c_p1 < cols_eff);
    n1 = seq_next(pos_c, cols_eff);
    n2 = seq_next(n1, cols_eff);
  end

  // Line entry layout: row two above in the upper half, row one above below.
  always_comb begin
    centre = a_r[VALUE_BITS-1:0];
    op_nxt.centre = centre;
    op_nxt.up     = a_r[ENTRY_BITS-1:VALUE_BITS];
    op_nxt.down   = cell_value;
    op_nxt.right  = has_right ? value_t'(ram_rdata[VALUE_BITS-1:0]) : '0;
    op_nxt.left   = (pos_c != '0) ? prev_centre_r : '0;
    op_nxt.flags.emit_relaxed = (pos_row != '0);
    op_nxt.flags.emit_border  = (pos_row == rows_eff - CFG_ROWS_BITS'(1));
    op_nxt.flags.interior     = (pos_row >= CFG_ROWS_BITS'(2)) && (pos_c != '0) && has_right;
    op_nxt.flags.sweep_end    = op_nxt.flags.emit_border && !has_right;
    op_nxt.flags.sweep_start  = (pos_row == '0) && (pos_c == '0);
  end

  always_comb begin
    state_nxt       = state_r;
    clr_addr_nxt    = clr_addr_r;
    grid_cols_nxt   = grid_cols_r;
    grid_rows_nxt   = grid_rows_r;
    col_nxt         = col_r;
    row_nxt         = row_r;
    a_nxt           = a_r;
    prev_centre_nxt = prev_centre_r;
    ram_we          = 1'b0;
    ram_waddr       = pos_c[AW-1:0];
    ram_wdata       = {centre, cell_value};
    ram_re          = 1'b0;
    ram_raddr       = n2[AW-1:0];

    unique case (state_r)
      ST_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        ram_wdata    = '0;
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(MAX_COLS - 1)) begin
          state_nxt = ST_FETCH_CUR;
        end
      end
      ST_FETCH_CUR: begin
        ram_re    = 1'b1;
        ram_raddr = pos_c[AW-1:0];
        state_nxt = ST_FETCH_NEXT;
      end
      ST_FETCH_NEXT: begin
        ram_re    = 1'b1;
        ram_raddr = n1[AW-1:0];
        a_nxt     = ram_rdata;
        state_nxt = ST_RUN;
      end
      ST_RUN: begin
        // The read data register always holds the entry of the next position;
        // each request fetches the entry two positions ahead.
        if (accept) begin
          ram_we          = 1'b1;
          ram_re          = 1'b1;
          a_nxt           = ram_rdata;
          prev_centre_nxt = centre;
          col_nxt         = pos_c_p1;
          row_nxt         = pos_row;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase

    // A size change breaks the prefetched sequence, so fetch it again.
    if (cfg_we) begin
      unique case (cfg_idx)
        REG_GRID_COLS: grid_cols_nxt = cfg_wdata[CFG_COLS_BITS-1:0];
        REG_GRID_ROWS: grid_rows_nxt = cfg_wdata[CFG_ROWS_BITS-1:0];
        default: ;
      endcase
      if (state_r != ST_CLEAR) begin
        state_nxt = ST_FETCH_CUR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      grid_cols_r <= CFG_COLS_BITS'(4096);
      grid_rows_r <= CFG_ROWS_BITS'(4096);
      col_r       <= '0;
      row_r       <= '0;
      op_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      grid_cols_r <= grid_cols_nxt;
      grid_rows_r <= grid_rows_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      op_valid_r  <= accept;
    end
    a_r           <= a_nxt;
    prev_centre_r <= prev_centre_nxt;
    if (accept) begin
      op_r <= op_nxt;
    end
  end

  assign run      = (state_r == ST_RUN);
  assign op_valid = op_valid_r;
  assign op       = op_r;

endmodule

`default_nettype wire

@@ rtl/jls_relax.sv @@
// Stencil arithmetic: quarter sum, change measure and running maximum.
`timescale 1ns / 1ps
`default_nettype none

module jls_relax (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           op_valid,
  input  jls_pkg::operands_t             op,
  output jls_pkg::push_t                 push,
  output logic [jls_pkg::PEND_BITS-1:0]  pend
);

  import jls_pkg::*;

  localparam int PW = VALUE_BITS + 1;
  localparam int SW = VALUE_BITS + 2;

  // Stage A: pair sums.
  logic                    a_valid_r;
  logic signed [PW-1:0]    a_lr_r, a_ud_r;
  value_t                  a_centre_r, a_down_r;
  flags_t                  a_flags_r;
  // Stage B: relaxed value.
  logic                    b_valid_r;
  value_t                  b_nv_r, b_centre_r, b_down_r;
  flags_t                  b_flags_r;
  // Stage C: absolute change.
  logic                    c_valid_r;
  logic [VALUE_BITS-1:0]   c_ch_r;
  value_t                  c_nv_r, c_down_r;
  flags_t                  c_flags_r;

  logic [VALUE_BITS-1:0]   max_r, max_nxt, base;

  logic signed [SW-1:0]    sum;
  value_t                  nv;
  logic signed [PW-1:0]    diff;
  logic [PW-1:0]           diff_abs;
  result_t                 res_relaxed, res_border;

  always_comb begin
    // The shift by two of the full-width sum rounds toward minus infinity.
    sum = {a_lr_r[PW-1], a_lr_r} + {a_ud_r[PW-1], a_ud_r};
    nv  = a_flags_r.interior ? value_t'(sum[SW-1:2]) : a_centre_r;

    diff     = {b_nv_r[VALUE_BITS-1], b_nv_r} - {b_centre_r[VALUE_BITS-1], b_centre_r};
    diff_abs = diff[PW-1] ? PW'(-diff) : PW'(diff);

    base    = c_flags_r.sweep_start ? '0 : max_r;
    max_nxt = (c_flags_r.emit_relaxed && (c_ch_r > base)) ? c_ch_r : base;

    res_relaxed.new_value  = c_nv_r;
    res_relaxed.sweep_last = 1'b0;
    res_relaxed.max_change = '0;
    res_border.new_value   = c_down_r;
    res_border.sweep_last  = c_flags_r.sweep_end;
    res_border.max_change  = c_flags_r.sweep_end ? max_nxt : '0;

    push.count  = c_valid_r ? (2'(c_flags_r.emit_relaxed) + 2'(c_flags_r.emit_border)) : 2'd0;
    push.first  = c_flags_r.emit_relaxed ? res_relaxed : res_border;
    push.second = res_border;

    // Stage C counts too: its results enter the queue only at the next edge.
    pend = (a_valid_r ? PEND_BITS'(a_flags_r.emit_relaxed) + PEND_BITS'(a_flags_r.emit_border)
                      : PEND_BITS'(0))
         + (b_valid_r ? PEND_BITS'(b_flags_r.emit_relaxed) + PEND_BITS'(b_flags_r.emit_border)
                      : PEND_BITS'(0))
         + (c_valid_r ? PEND_BITS'(c_flags_r.emit_relaxed) + PEND_BITS'(c_flags_r.emit_border)
                      : PEND_BITS'(0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
      max_r     <= '0;
    end else begin
      a_valid_r <= op_valid;
      b_valid_r <= a_valid_r;
      c_valid_r <= b_valid_r;
      if (c_valid_r) begin
        max_r <= max_nxt;
      end
    end
    a_lr_r     <= {op.left[VALUE_BITS-1], op.left} + {op.right[VALUE_BITS-1], op.right};
    a_ud_r     <= {op.up[VALUE_BITS-1], op.up} + {op.down[VALUE_BITS-1], op.down};
    a_centre_r <= op.centre;
    a_down_r   <= op.down;
    a_flags_r  <= op.flags;
    b_nv_r     <= nv;
    b_centre_r <= a_centre_r;
    b_down_r   <= a_down_r;
    b_flags_r  <= a_flags_r;
    c_ch_r     <= diff_abs[VALUE_BITS-1:0];
    c_nv_r     <= b_nv_r;
    c_down_r   <= b_down_r;
    c_flags_r  <= b_flags_r;
  end

endmodule

`default_nettype wire

@@ rtl/jls_out_fifo.sv @@
// Result queue that takes up to two results a cycle and hands out one.
`timescale 1ns / 1ps
`default_nettype none

module jls_out_fifo (
  input  logic                               clk,
  input  logic                               rst_n,
  input  jls_pkg::push_t                     push,
  input  logic                               pop,
  output jls_pkg::result_t                   head,
  output logic                               not_empty,
  output logic [jls_pkg::FIFO_CNT_BITS-1:0]  count
);

  import jls_pkg::*;

  result_t                  mem [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_BITS-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + FIFO_PTR_BITS'(push.count);
    rd_ptr_nxt = rd_ptr_r + FIFO_PTR_BITS'(pop);
    count_nxt  = count_r + FIFO_CNT_BITS'(push.count) - FIFO_CNT_BITS'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push.count != 2'd0) begin
      mem[wr_ptr_r] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr_r + FIFO_PTR_BITS'(1)] <= push.second;
    end
  end

  assign head      = mem[rd_ptr_r];
  assign not_empty = (count_r != '0);
  assign count     = count_r;

endmodule

`default_nettype wire

@@ rtl/jacobi_laplace_sweep_unit.sv @@
// Top level of the Jacobi four-point stencil sweep unit.
`timescale 1ns / 1ps
`default_nettype none

// One Jacobi relaxation sweep over a grid streamed in row-major order as
// signed Q16.16 cells. Interior cells become the quarter sum of their four
// neighbors (rounded toward minus infinity); border cells pass unchanged.
// Results lag the input by one row, and each cell of the last row gives two
// results, the relaxed cell above it and then itself. The final result of a
// sweep carries tlast and the largest absolute change of the sweep. The unit
// takes one cell per clock while the result queue has room; over the last
// row the single result port sets the pace. Results pass the operand
// register, stages A, B and C and the result queue. Reset clears the line
// buffer memory; after that or any register write the fetch states refill
// the read-ahead, during which no request is taken. The user must write
// grid size registers only while the unit is idle; it is not enforced. The
// column count is clamped to 3..MAX_COLS, rows raised to at least 3.
module jacobi_laplace_sweep_unit #(
  parameter int MAX_COLS = 4096
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [jls_pkg::CFG_IDX_BITS-1:0]    cfg_idx,
  input  logic [jls_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [jls_pkg::IN_TDATA_BITS-1:0]   in_tdata,   // [31:0] cell_value
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [jls_pkg::OUT_TDATA_BITS-1:0]  out_tdata,  // [31:0] new_value, [63:32] max_change
  output logic                                out_tlast
);

  import jls_pkg::*;

  logic                       accept, run, op_valid, pop;
  operands_t                  op;
  push_t                      push;
  logic [PEND_BITS-1:0]       relax_pend;
  logic [1:0]                 op_pend;
  logic [RESERVE_BITS-1:0]    reserve;
  result_t                    head;
  logic [FIFO_CNT_BITS-1:0]   fifo_count;

  jls_window #(
    .MAX_COLS (MAX_COLS)
  ) u_window (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .accept     (accept),
    .cell_value (value_t'(in_tdata[VALUE_BITS-1:0])),
    .run        (run),
    .op_valid   (op_valid),
    .op         (op)
  );

  jls_relax u_relax (
    .clk      (clk),
    .rst_n    (rst_n),
    .op_valid (op_valid),
    .op       (op),
    .push     (push),
    .pend     (relax_pend)
  );

  jls_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (pop),
    .head      (head),
    .not_empty (out_tvalid),
    .count     (fifo_count)
  );

  // Every result still in the pipeline holds a queue slot, and a request is
  // taken only while two more slots remain.
  always_comb begin
    op_pend = op_valid ? (2'(op.flags.emit_relaxed) + 2'(op.flags.emit_border)) : 2'd0;
    reserve = RESERVE_BITS'(fifo_count) + RESERVE_BITS'(op_pend) + RESERVE_BITS'(relax_pend);
  end

  assign in_tready = run && (reserve <= RESERVE_BITS'(FIFO_DEPTH - 2));
  assign accept    = in_tvalid && in_tready;
  assign pop       = out_tvalid && out_tready;
  assign out_tdata = {head.max_change, head.new_value};
  assign out_tlast = head.sweep_last;

  a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
    push.count != 2'd0 |->
      ((FIFO_CNT_BITS + 1)'(fifo_count) + (FIFO_CNT_BITS + 1)'(push.count)
        <= (FIFO_CNT_BITS + 1)'(FIFO_DEPTH)))
    else $error("result queue would overflow");

  a_max_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[OUT_TDATA_BITS-1:VALUE_BITS] == '0)
    else $error("maximum change reported on a result that does not end the sweep");

  a_no_request_when_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cfg_we) |-> !in_tready)
    else $error("request taken before the read-ahead was refilled");

endmodule

`default_nettype wire
